### sv/lcom_pkg.sv
// ----------------------------------------------------------------------------
// lcom_pkg
// Shared types and constants of the lidar curvature and occlusion marker.
// ----------------------------------------------------------------------------
package lcom_pkg;

  localparam int RANGE_MM_W = 20;
  localparam int COLUMN_W   = 12;
  localparam int INDEX_W    = 18;
  localparam int CURV_W     = 47;
  localparam int GAP_W      = 20;
  localparam int BEAM_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // window cells, output delay, neighbours per side, forward mark run
  localparam int WIN       = 11;
  localparam int DELAY     = 6;
  localparam int NBR       = 5;
  localparam int FWD_MARKS = 5;
  localparam int K_W       = 3;

  localparam logic [GAP_W-1:0]    OCCL_GAP_RST = GAP_W'(300);
  localparam logic [COLUMN_W-1:0] COL_GAP_RST  = COLUMN_W'(10);
  localparam logic [BEAM_W-1:0]   BEAM_INV_RST = BEAM_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCCLUSION_GAP    = 2'd0,
    CFG_COLUMN_GAP_LIMIT = 2'd1,
    CFG_BEAM_RATIO_INV   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic back;
    logic fwd;
    logic beam;
  } pair_marks_t;

  typedef struct packed {
    logic curv_valid;
    logic unreliable;
    logic last;
  } emit_flags_t;

endpackage

### sv/lcom_cell.sv
// ----------------------------------------------------------------------------
// lcom_cell
// One window cell: range, column and mark of one point, shifted to the next
// cell on every window step.
// ----------------------------------------------------------------------------
module lcom_cell import lcom_pkg::*; #(
  parameter int RANGE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  clear_i,
  input  logic [RANGE_BITS-1:0] range_i,
  input  logic [COLUMN_W-1:0]   column_i,
  input  logic                  mark_i,
  input  logic                  set_mark_i,
  output logic [RANGE_BITS-1:0] range_o,
  output logic [COLUMN_W-1:0]   column_o,
  output logic                  mark_o
);

  logic [RANGE_BITS-1:0] range_q;
  logic [COLUMN_W-1:0]   column_q;
  logic                  mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= '0;
      column_q <= '0;
      mark_q   <= 1'b0;
    end else if (clear_i) begin
      range_q  <= '0;
      column_q <= '0;
      mark_q   <= 1'b0;
    end else if (shift_i) begin
      range_q  <= range_i;
      column_q <= column_i;
      mark_q   <= mark_i | set_mark_i;
    end
  end

  assign range_o  = range_q;
  assign column_o = column_q;
  assign mark_o   = mark_q;

endmodule

### sv/lcom_pair_test.sv
// ----------------------------------------------------------------------------
// lcom_pair_test
// Occlusion and parallel beam tests between the arriving point and the two
// newest window cells.
// ----------------------------------------------------------------------------
module lcom_pair_test import lcom_pkg::*; #(
  parameter int RANGE_BITS = 20
) (
  input  logic                  en_i,
  input  logic [RANGE_BITS-1:0] r0_i,
  input  logic [RANGE_BITS-1:0] r1_i,
  input  logic [RANGE_BITS-1:0] r2_i,
  input  logic [COLUMN_W-1:0]   c0_i,
  input  logic [COLUMN_W-1:0]   c1_i,
  input  logic [GAP_W-1:0]      occl_gap_i,
  input  logic [COLUMN_W-1:0]   col_gap_i,
  input  logic [BEAM_W-1:0]     beam_inv_i,
  output pair_marks_t           marks_o
);

  localparam int CMP_W  = (RANGE_BITS > GAP_W) ? RANGE_BITS : GAP_W;
  localparam int PROD_W = RANGE_BITS + BEAM_W;

  logic [COLUMN_W-1:0]   col_diff;
  logic                  adjacent;
  logic [RANGE_BITS-1:0] d01;
  logic [RANGE_BITS-1:0] d21;
  logic [PROD_W-1:0]     p01;
  logic [PROD_W-1:0]     p21;
  logic                  gap_big;

  assign col_diff = (c1_i > c0_i) ? (c1_i - c0_i) : (c0_i - c1_i);
  assign adjacent = col_diff < col_gap_i;
  assign d01      = (r0_i > r1_i) ? (r0_i - r1_i) : (r1_i - r0_i);
  assign d21      = (r2_i > r1_i) ? (r2_i - r1_i) : (r1_i - r2_i);
  assign gap_big  = CMP_W'(d01) > CMP_W'(occl_gap_i);
  assign p01      = PROD_W'(d01) * PROD_W'(beam_inv_i);
  assign p21      = PROD_W'(d21) * PROD_W'(beam_inv_i);

  assign marks_o.back = en_i & adjacent & (r1_i > r0_i) & gap_big;
  assign marks_o.fwd  = en_i & adjacent & (r0_i > r1_i) & gap_big;
  assign marks_o.beam = en_i & (p21 > PROD_W'(r1_i)) & (p01 > PROD_W'(r1_i));

endmodule

### sv/lcom_out_pipe.sv
// ----------------------------------------------------------------------------
// lcom_out_pipe
// Two result stages: curvature magnitude, then its saturated square in the
// output register.
// ----------------------------------------------------------------------------
module lcom_out_pipe import lcom_pkg::*; #(
  parameter int RANGE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  emit_valid_i,
  input  logic [INDEX_W-1:0]    emit_index_i,
  input  logic [RANGE_BITS+3:0] emit_mag_i,
  input  emit_flags_t           emit_flags_i,
  output logic                  s1_free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [INDEX_W-1:0]    point_index_o,
  output logic [CURV_W-1:0]     curvature_o,
  output logic                  curvature_valid_o,
  output logic                  unreliable_o,
  output logic                  last_result_o
);

  localparam int MAG_W = RANGE_BITS + 4;
  localparam int SQ_W  = 2 * MAG_W;

  logic                 s1_valid_q;
  logic [INDEX_W-1:0]   s1_index_q;
  logic [MAG_W-1:0]     s1_mag_q;
  emit_flags_t          s1_flags_q;
  logic                 s2_valid_q;
  logic [INDEX_W-1:0]   s2_index_q;
  logic [CURV_W-1:0]    s2_curv_q;
  emit_flags_t          s2_flags_q;
  logic                 s2_free;
  logic [SQ_W-1:0]      sq;
  logic [CURV_W-1:0]    curv_sat;

  assign s2_free   = ~s2_valid_q | ~out_stall_i;
  assign s1_free_o = ~s1_valid_q | s2_free;
  assign sq        = SQ_W'(s1_mag_q) * SQ_W'(s1_mag_q);

  if (SQ_W > CURV_W) begin : g_sat
    assign curv_sat = (|sq[SQ_W-1:CURV_W]) ? '1 : sq[CURV_W-1:0];
  end else begin : g_nosat
    assign curv_sat = CURV_W'(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= emit_valid_i | (s1_valid_q & ~s2_free);
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid_i) begin
      s1_index_q <= emit_index_i;
      s1_mag_q   <= emit_flags_i.curv_valid ? emit_mag_i : '0;
      s1_flags_q <= emit_flags_i;
    end
    if (s2_free && s1_valid_q) begin
      s2_index_q <= s1_index_q;
      s2_curv_q  <= curv_sat;
      s2_flags_q <= s1_flags_q;
    end
  end

  assign out_valid_o       = s2_valid_q;
  assign point_index_o     = s2_index_q;
  assign curvature_o       = s2_curv_q;
  assign curvature_valid_o = s2_flags_q.curv_valid;
  assign unreliable_o      = s2_flags_q.unreliable;
  assign last_result_o     = s2_flags_q.last;

endmodule

### sv/lidar_curvature_occlusion_marker.sv
// ----------------------------------------------------------------------------
// lidar_curvature_occlusion_marker
// Scan curvature and unreliable point marking over a sliding point window.
// ----------------------------------------------------------------------------
// Takes one point per clock unless in_stall_o is high. Each accepted point
// shifts a chain of eleven window cells and a running range sum, and releases
// the result for the point six places back, which reaches the output register
// through the two result stages. A point with last_point set releases its own
// result and up to six more: the block then stalls its input while the chain
// shifts the cloud tail out one result per cycle when the result stages are
// free, and clears itself after the final result. A stall on the output side
// backs up through the two result stages into the input stall.
module lidar_curvature_occlusion_marker import lcom_pkg::*; #(
  parameter int MAX_POINTS = 262144,
  parameter int RANGE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RANGE_MM_W-1:0] range_mm_i,
  input  logic [COLUMN_W-1:0]   column_i,
  input  logic                  last_point_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [INDEX_W-1:0]    point_index_o,
  output logic [CURV_W-1:0]     curvature_o,
  output logic                  curvature_valid_o,
  output logic                  unreliable_o,
  output logic                  last_result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam int SUM_W = RANGE_BITS + 4;

  logic [GAP_W-1:0]      occl_gap_q;
  logic [COLUMN_W-1:0]   col_gap_q;
  logic [BEAM_W-1:0]     beam_inv_q;
  logic [CNT_W-1:0]      count_q;
  logic [K_W-1:0]        fwd_left_q;
  logic [K_W-1:0]        flush_k_q;
  logic                  flush_q;
  logic [SUM_W-1:0]      sum_q;

  logic [RANGE_BITS-1:0] range_w  [WIN];
  logic [COLUMN_W-1:0]   column_w [WIN];
  logic                  mark_w   [WIN];

  logic                  s1_free;
  logic                  step_real;
  logic                  step_bub;
  logic                  shift;
  logic                  clear;
  logic [RANGE_BITS-1:0] in_range;
  logic [RANGE_BITS-1:0] shift_range;
  logic [COLUMN_W-1:0]   shift_column;
  logic                  head_mark;
  pair_marks_t           marks;
  logic [K_W-1:0]        k;
  logic [CNT_W-1:0]      j_full;
  logic                  emit_valid;
  emit_flags_t           emit_flags;
  logic [SUM_W:0]        r5x11;
  logic [SUM_W:0]        diff;
  logic [SUM_W:0]        neg;
  logic [SUM_W-1:0]      mag;

  assign cfg_ready_o = 1'b1;

  assign step_real    = in_valid_i & ~in_stall_o;
  assign step_bub     = flush_q & s1_free;
  assign shift        = step_real | step_bub;
  assign clear        = step_bub & (flush_k_q == '0);
  assign in_stall_o   = flush_q | ~s1_free;
  assign in_range     = RANGE_BITS'(range_mm_i);
  assign shift_range  = flush_q ? '0 : in_range;
  assign shift_column = flush_q ? '0 : column_i;
  assign head_mark    = step_real & ((fwd_left_q != '0) | marks.fwd);

  lcom_pair_test #(
    .RANGE_BITS(RANGE_BITS)
  ) u_pair (
    .en_i      (~flush_q & (count_q >= CNT_W'(DELAY))),
    .r0_i      (in_range),
    .r1_i      (range_w[0]),
    .r2_i      (range_w[1]),
    .c0_i      (column_i),
    .c1_i      (column_w[0]),
    .occl_gap_i(occl_gap_q),
    .col_gap_i (col_gap_q),
    .beam_inv_i(beam_inv_q),
    .marks_o   (marks)
  );

  for (genvar g = 0; g < WIN; g++) begin : g_cell
    logic [RANGE_BITS-1:0] rin;
    logic [COLUMN_W-1:0]   cin;
    logic                  min;
    logic                  set;
    if (g == 0) begin : g_head
      assign rin = shift_range;
      assign cin = shift_column;
      assign min = head_mark;
      assign set = 1'b0;
    end else begin : g_body
      assign rin = range_w[g-1];
      assign cin = column_w[g-1];
      assign min = mark_w[g-1];
      assign set = ((g <= DELAY) && marks.back) || ((g == 1) && marks.beam);
    end
    lcom_cell #(
      .RANGE_BITS(RANGE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .clear_i   (clear),
      .range_i   (rin),
      .column_i  (cin),
      .mark_i    (min),
      .set_mark_i(set),
      .range_o   (range_w[g]),
      .column_o  (column_w[g]),
      .mark_o    (mark_w[g])
    );
  end

  // result leaves from the cell that becomes age six after this step
  assign k          = flush_q ? flush_k_q : K_W'(DELAY);
  assign j_full     = count_q - CNT_W'(k);
  assign emit_valid = shift & (CNT_W'(k) <= count_q);

  assign emit_flags.curv_valid = (k >= K_W'(NBR)) & (j_full >= CNT_W'(NBR));
  assign emit_flags.unreliable = mark_w[DELAY-1] | marks.back;
  assign emit_flags.last       = flush_q & (k == '0);

  assign r5x11 = (SUM_W+1)'({range_w[DELAY-1], 3'b000})
               + (SUM_W+1)'({range_w[DELAY-1], 1'b0})
               + (SUM_W+1)'(range_w[DELAY-1]);
  assign diff  = {1'b0, sum_q} - r5x11;
  assign neg   = ~diff + 1'b1;
  assign mag   = diff[SUM_W] ? neg[SUM_W-1:0] : diff[SUM_W-1:0];

  lcom_out_pipe #(
    .RANGE_BITS(RANGE_BITS)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .emit_valid_i     (emit_valid),
    .emit_index_i     (INDEX_W'(j_full)),
    .emit_mag_i       (mag),
    .emit_flags_i     (emit_flags),
    .s1_free_o        (s1_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .point_index_o    (point_index_o),
    .curvature_o      (curvature_o),
    .curvature_valid_o(curvature_valid_o),
    .unreliable_o     (unreliable_o),
    .last_result_o    (last_result_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occl_gap_q <= OCCL_GAP_RST;
      col_gap_q  <= COL_GAP_RST;
      beam_inv_q <= BEAM_INV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_OCCLUSION_GAP:    occl_gap_q <= GAP_W'(cfg_data_i);
        CFG_COLUMN_GAP_LIMIT: col_gap_q  <= COLUMN_W'(cfg_data_i);
        CFG_BEAM_RATIO_INV:   beam_inv_q <= BEAM_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      fwd_left_q <= '0;
      flush_k_q  <= '0;
      flush_q    <= 1'b0;
      sum_q      <= '0;
    end else if (clear) begin
      count_q    <= '0;
      fwd_left_q <= '0;
      flush_k_q  <= '0;
      flush_q    <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (shift) begin
        sum_q <= sum_q + SUM_W'(shift_range) - SUM_W'(range_w[WIN-1]);
      end
      if (step_bub) begin
        flush_k_q <= flush_k_q - 1'b1;
      end
      if (step_real) begin
        if (marks.fwd) begin
          fwd_left_q <= K_W'(FWD_MARKS);
        end else if (fwd_left_q != '0) begin
          fwd_left_q <= fwd_left_q - 1'b1;
        end
        if (last_point_i) begin
          flush_q   <= 1'b1;
          flush_k_q <= K_W'(DELAY - 1);
        end else if (count_q < CNT_W'(MAX_POINTS - 1)) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

endmodule

### test/lidar_curvature_occlusion_marker_tb.sv
// ----------------------------------------------------------------------------
// lidar_curvature_occlusion_marker_tb
// Self-checking bench for the scan curvature and occlusion marker. A short
// table of directed points is followed by random point clouds under several
// register settings and idle patterns. Every point transfer runs through a
// local window model, and each result transfer is compared field by field
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module lidar_curvature_occlusion_marker_tb;
  import lcom_pkg::*;

  localparam int          HIST       = 12;
  localparam int unsigned CLOUD_MAX  = 262144;
  localparam int          QUIET      = 16;
  localparam int          SEG_POINTS = 48;
  localparam int          RANGE_TOP  = (1 << RANGE_MM_W) - 1;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [CURV_W-1:0]  curv;
    logic               curv_ok;
    logic               unrel;
    logic               last;
  } point_result_t;

  typedef struct {
    logic [RANGE_MM_W-1:0] range_mm;
    logic [COLUMN_W-1:0]   column;
    logic                  last;
    logic                  typed;
    point_result_t         res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [RANGE_MM_W-1:0] range_mm   = '0;
  logic [COLUMN_W-1:0]   column     = '0;
  logic                  last_point = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [INDEX_W-1:0]    point_index;
  logic [CURV_W-1:0]     curvature;
  logic                  curvature_valid;
  logic                  unreliable;
  logic                  last_result;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // local copy of the block state and registers
  logic [RANGE_MM_W-1:0] rng_win[HIST];
  logic [COLUMN_W-1:0]   col_win[HIST];
  bit                    mark_win[HIST];
  int unsigned           fwd_left;
  int unsigned           pt_cnt;
  logic [GAP_W-1:0]      occl_gap   = OCCL_GAP_RST;
  logic [COLUMN_W-1:0]   col_limit  = COL_GAP_RST;
  logic [BEAM_W-1:0]     beam_inv   = BEAM_INV_RST;

  point_result_t pending_results[$];
  int tx_idle = 0;
  int rx_idle = 0;
  int unsigned points_sent, clouds_sent, results_checked, mismatches, settings_used;

  lidar_curvature_occlusion_marker i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .range_mm_i        (range_mm),
    .column_i          (column),
    .last_point_i      (last_point),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .point_index_o     (point_index),
    .curvature_o       (curvature),
    .curvature_valid_o (curvature_valid),
    .unreliable_o      (unreliable),
    .last_result_o     (last_result),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic void clear_cloud();
    for (int k = 0; k < HIST; k++) begin
      rng_win[k]  = '0;
      col_win[k]  = '0;
      mark_win[k] = 1'b0;
    end
    fwd_left = 0;
    pt_cnt   = 0;
  endfunction

  function automatic void queue_result(input int unsigned p, input int k, input bit last);
    int unsigned   j;
    longint        s;
    longint        m;
    point_result_t r;
    j = p - k;
    s = 0;
    r = '0;
    r.idx     = j[INDEX_W-1:0];
    r.curv_ok = (k >= NBR && k <= DELAY && j >= NBR);
    if (r.curv_ok) begin
      for (int d = 1; d <= NBR; d++) s += longint'(rng_win[k-d]) + longint'(rng_win[k+d]);
      s -= 10 * longint'(rng_win[k]);
      m = s < 0 ? -s : s;
      m = m * m;
      r.curv = m > (64'd1 << CURV_W) - 1 ? {CURV_W{1'b1}} : m[CURV_W-1:0];
    end
    r.unrel = mark_win[k];
    r.last  = last && k == 0;
    pending_results = {pending_results, r};
  endfunction

  // shift one point into the window, apply pair and beam marks, queue results
  function automatic void mark_and_curve(input logic [RANGE_MM_W-1:0] r,
                                         input logic [COLUMN_W-1:0] c, input bit last);
    int unsigned p;
    int unsigned r0, r1, r2;
    int          top;
    p = pt_cnt;
    for (int k = HIST - 1; k > 0; k--) begin
      rng_win[k]  = rng_win[k-1];
      col_win[k]  = col_win[k-1];
      mark_win[k] = mark_win[k-1];
    end
    rng_win[0]  = r;
    col_win[0]  = c;
    mark_win[0] = 1'b0;
    if (fwd_left > 0) begin
      mark_win[0] = 1'b1;
      fwd_left--;
    end
    if (p >= DELAY) begin
      r0 = 32'(rng_win[0]);
      r1 = 32'(rng_win[1]);
      r2 = 32'(rng_win[2]);
      if (span(32'(col_win[1]), 32'(col_win[0])) < 32'(col_limit)) begin
        if (r1 > r0 && r1 - r0 > 32'(occl_gap)) begin
          for (int k = 1; k <= DELAY; k++) mark_win[k] = 1'b1;
        end else if (r0 > r1 && r0 - r1 > 32'(occl_gap)) begin
          mark_win[0] = 1'b1;
          fwd_left    = FWD_MARKS;
        end
      end
      if (longint'(span(r2, r1)) * longint'(beam_inv) > longint'(r1) &&
          longint'(span(r0, r1)) * longint'(beam_inv) > longint'(r1))
        mark_win[1] = 1'b1;
    end
    if (!last) begin
      if (p >= DELAY) queue_result(p, DELAY, 1'b0);
      if (pt_cnt < CLOUD_MAX - 1) pt_cnt++;
    end else begin
      top = p >= DELAY ? DELAY : int'(p);
      for (int k = top; k >= 0; k--) queue_result(p, k, 1'b1);
      clear_cloud();
    end
  endfunction

  task automatic send_point(input logic [RANGE_MM_W-1:0] r, input logic [COLUMN_W-1:0] c,
                            input logic last, input logic typed, input point_result_t res);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    range_mm   <= r;
    column     <= c;
    last_point <= last;
    do @(posedge clk); while (in_stall);
    mark_and_curve(r, c, last);
    if (typed) begin
      pending_results[pending_results.size() - 1] = res;
    end
    points_sent++;
    if (last) clouds_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic cfg_xfer(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OCCLUSION_GAP:    occl_gap  = data[GAP_W-1:0];
      CFG_COLUMN_GAP_LIMIT: col_limit = data[COLUMN_W-1:0];
      CFG_BEAM_RATIO_INV:   beam_inv  = data[BEAM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [GAP_W-1:0] gap, input logic [COLUMN_W-1:0] cgap,
                            input logic [BEAM_W-1:0] beam);
    cfg_xfer(CFG_OCCLUSION_GAP, CFG_DATA_W'(gap));
    cfg_xfer(CFG_COLUMN_GAP_LIMIT, CFG_DATA_W'(cgap));
    cfg_xfer(CFG_BEAM_RATIO_INV, CFG_DATA_W'(beam));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // smooth scan with steps, spikes and column jumps; noisy clouds are raw random
  task automatic send_cloud(input int len, input bit noisy);
    int          v;
    int unsigned col;
    int unsigned sel;
    v   = $urandom_range(4) == 0 ? $urandom_range(RANGE_TOP) : $urandom_range(500, 60000);
    col = $urandom_range((1 << COLUMN_W) - 1);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (noisy || sel < 3) begin
        v   = $urandom_range(RANGE_TOP);
        col = $urandom;
      end else begin
        if (sel < 15) v += $urandom_range(1) ? $urandom_range(200, 30000)
                                              : -$urandom_range(200, 30000);
        else v += $urandom_range(120) - 60;
        col += sel >= 95 ? $urandom_range(11, 300) : $urandom_range(2);
      end
      if (v < 0) v = 0;
      if (v > RANGE_TOP) v = RANGE_TOP;
      send_point(v[RANGE_MM_W-1:0], col[COLUMN_W-1:0], i == len - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= $urandom_range(99) < rx_idle;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: index %0d curvature %0d", point_index, curvature);
      end else begin
        point_result_t e;
        e = pending_results.pop_front();
        results_checked++;
        if (e.idx !== point_index || e.curv !== curvature || e.curv_ok !== curvature_valid ||
            e.unrel !== unreliable || e.last !== last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d curv %0d cv %0b unrel %0b last %0b, got idx %0d curv %0d cv %0b unrel %0b last %0b",
                     e.idx, e.curv, e.curv_ok, e.unrel, e.last, point_index, curvature,
                     curvature_valid, unreliable, last_result);
        end
      end
    end
  end

  initial begin
    dir_row_t    dir_rows[23];
    int          seg_points;
    int unsigned v;
    dir_rows = '{
      '{20'hFFFFF, 12'hFFF, 1'b1, 1'b1, '{18'd0, 47'd0, 1'b0, 1'b0, 1'b1}},
      '{20'd0,     12'd0,   1'b1, 1'b1, '{18'd0, 47'd0, 1'b0, 1'b0, 1'b1}},
      '{20'd1000,  12'd0,   1'b0, 1'b0, '0},
      '{20'd1000,  12'd1,   1'b0, 1'b0, '0},
      '{20'd1234,  12'd2,   1'b1, 1'b0, '0},
      '{20'd5000,  12'd100, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd101, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd102, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd103, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd104, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd105, 1'b0, 1'b0, '0},
      '{20'd5000,  12'd106, 1'b0, 1'b0, '0},
      '{20'd2000,  12'd107, 1'b0, 1'b0, '0},
      '{20'd2000,  12'd108, 1'b0, 1'b0, '0},
      '{20'd2000,  12'd109, 1'b0, 1'b0, '0},
      '{20'd3000,  12'd110, 1'b0, 1'b0, '0},
      '{20'd2000,  12'd111, 1'b0, 1'b0, '0},
      '{20'd2000,  12'd112, 1'b0, 1'b0, '0},
      '{20'd9000,  12'd113, 1'b0, 1'b0, '0},
      '{20'd9000,  12'd114, 1'b0, 1'b0, '0},
      '{20'd9000,  12'd115, 1'b0, 1'b0, '0},
      '{20'd9000,  12'd116, 1'b0, 1'b0, '0},
      '{20'd9000,  12'd117, 1'b1, 1'b0, '0}
    };
    clear_cloud();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under reset settings
    tx_idle = 14;
    rx_idle = 73;
    foreach (dir_rows[i])
      send_point(dir_rows[i].range_mm, dir_rows[i].column, dir_rows[i].last,
                 dir_rows[i].typed, dir_rows[i].res);

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      case (seg)
        0: set_config(GAP_W'(0), {COLUMN_W{1'b1}}, {BEAM_W{1'b1}});
        1: set_config({GAP_W{1'b1}}, COLUMN_W'(0), BEAM_W'(1));
        2: set_config(OCCL_GAP_RST, COL_GAP_RST, BEAM_W'(0));
        3: set_config(GAP_W'($urandom_range(2000)), COLUMN_W'($urandom_range(1, 20)),
                      BEAM_W'($urandom_range(1, 100)));
        4: set_config(GAP_W'($urandom), COLUMN_W'($urandom), BEAM_W'($urandom_range(1, 1023)));
        default: set_config(OCCL_GAP_RST, COL_GAP_RST, BEAM_INV_RST);
      endcase
      case (seg / 2)
        0: begin tx_idle = 14; rx_idle = 73; end
        1: begin tx_idle = 73; rx_idle = 14; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      seg_points = 0;
      while (seg_points < SEG_POINTS) begin
        v = $urandom_range(99);
        if (v < 15) begin
          v = $urandom_range(1, DELAY);
          send_cloud(v, 1'b0);
        end else begin
          v = $urandom_range(7, 40);
          send_cloud(v, $urandom_range(9) == 0);
        end
        seg_points += v;
      end
    end

    drain();
    $display("covered %0d points in %0d clouds under %0d register settings",
             points_sent, clouds_sent, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
